>>> src/aip_pkg.sv
// Shared types and constants for the ASCII integer parser.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package aip_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_LEN_DEF    = 255;
  localparam int VALUE_BITS_DEF = 32;

  // Depth of the queue between classifier and parsers.
  localparam int QUEUE_DEPTH = 2;

  // Fixed port widths.
  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int OFFSET_W = 8;
  localparam int MODE_W   = 2;

  // Radix mode register codes.
  localparam logic [MODE_W-1:0] MODE_AUTO  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_DEC;

  // Classification of one character, as handed from front to back.
  typedef struct packed {
    logic       term;       // zero byte, ends the string
    logic       blank;      // space, tab, LF, VT, FF, CR
    logic       dec_digit;  // '0'..'9'
    logic       hex_digit;  // '0'..'9', 'a'..'f', 'A'..'F'
    logic       zero;       // '0'
    logic       plus;       // '+'
    logic       minus;      // '-'
    logic       ex;         // 'x' or 'X'
    logic [3:0] nib;        // digit value when dec_digit or hex_digit
  } char_class_t;

endpackage

`default_nettype wire

>>> src/ascii_integer_parser_core.sv
// ASCII integer parser, strtol style, one character per input word.
//
// Input channel (in_valid / in_stall / in_char_code): one character per word.
// A zero byte ends the string and produces exactly one output word holding
// the parsed value (two's complement, wrapped to VALUE_BITS and sign-extended
// to 32 bits) and the offset where parsing stopped (saturated at MAX_LEN).
// Output channel (out_valid / out_stall / out_parsed_value / out_stop_offset).
// cfg_wr_en / cfg_wr_data write radix_mode: 0 auto, 1 decimal, 2 hex. Write it
// only while no string is in flight.
//
// Throughput is one character per cycle while in_stall is low, set by the
// parser update in the back end. out_valid rises once the accepted zero byte
// has passed through the two-entry classify queue and loaded the output
// register. A stalled result is held in the output register
// while characters keep flowing into the parsers; the next zero byte waits
// in the queue, and in_stall rises once the queue is full. At reset the queue
// and parsers clear, in_stall is high, out_valid drops and radix_mode returns
// to decimal.
// Depends on aip_pkg, aip_front, aip_queue and aip_back.
`default_nettype none

module ascii_integer_parser_core #(
  parameter int MAX_LEN    = aip_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [aip_pkg::MODE_W-1:0]     cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [aip_pkg::CHAR_W-1:0]     in_char_code,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [aip_pkg::VALUE_W-1:0]  out_parsed_value,
  output logic [aip_pkg::OFFSET_W-1:0]        out_stop_offset
);

  logic [aip_pkg::MODE_W-1:0] radix_mode_r;
  logic                       q_full;
  logic                       q_push;
  aip_pkg::char_class_t       q_push_class;
  logic                       q_valid;
  aip_pkg::char_class_t       q_class;
  logic                       q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_mode_r <= aip_pkg::MODE_RESET;
    end else if (cfg_wr_en) begin
      radix_mode_r <= cfg_wr_data;
    end
  end

  aip_front u_front (
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_class (q_push_class)
  );

  aip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_class (q_push_class),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_class  (q_class),
    .pop        (q_pop)
  );

  aip_back #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .radix_mode       (radix_mode_r),
    .q_valid          (q_valid),
    .q_class          (q_class),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_parsed_value (out_parsed_value),
    .out_stop_offset  (out_stop_offset),
    .out_stall        (out_stall)
  );

endmodule

`default_nettype wire

>>> src/aip_front.sv
// Front end of the ASCII integer parser: accepts input words and classifies
// each character for the parsers. Depends on aip_pkg.
`default_nettype none

module aip_front (
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [aip_pkg::CHAR_W-1:0]   in_char_code,
  output logic                              in_stall,
  input  wire logic                         q_full,
  output logic                              q_push,
  output aip_pkg::char_class_t              q_push_class
);

  localparam logic [aip_pkg::CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [aip_pkg::CHAR_W-1:0] CH_LX    = 8'h78;

  logic [aip_pkg::CHAR_W-1:0] c;
  logic                       is_dec;
  logic                       is_upper;
  logic                       is_lower;
  logic [aip_pkg::CHAR_W-1:0] nib_full;

  assign c        = in_char_code;
  assign is_dec   = (c >= CH_0)  && (c <= CH_9);
  assign is_upper = (c >= CH_UA) && (c <= CH_UF);
  assign is_lower = (c >= CH_LA) && (c <= CH_LF);

  // Letters map to 10..15 by subtracting 'A' or 'a' and adding 10; digits by subtracting '0'.
  always_comb begin
    if (is_dec) begin
      nib_full = c - CH_0;
    end else if (is_upper) begin
      nib_full = c - CH_UA + 8'd10;
    end else begin
      nib_full = c - CH_LA + 8'd10;
    end
  end

  always_comb begin
    q_push_class.term      = (c == CH_NUL);
    q_push_class.blank     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    q_push_class.dec_digit = is_dec;
    q_push_class.hex_digit = is_dec || is_upper || is_lower;
    q_push_class.zero      = (c == CH_0);
    q_push_class.plus      = (c == CH_PLUS);
    q_push_class.minus     = (c == CH_MINUS);
    q_push_class.ex        = (c == CH_LX) || (c == CH_UX);
    q_push_class.nib       = nib_full[3:0];
  end

  // The queue is the front's storage; a word is taken whenever it has room and reset is released.
  assign in_stall = q_full || !rst_n;
  assign q_push   = in_valid && !in_stall;

endmodule

`default_nettype wire

>>> src/aip_queue.sv
// Short FIFO of classified characters between the front end and the parsers.
// Depends on aip_pkg for the entry type and depth.
`default_nettype none

module aip_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire aip_pkg::char_class_t push_class,
  output logic                      full,
  output logic                      pop_valid,
  output aip_pkg::char_class_t      pop_class,
  input  wire logic                 pop
);

  localparam int DEPTH = aip_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  aip_pkg::char_class_t entries_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_class = entries_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_class;
    end
  end

endmodule

`default_nettype wire

>>> src/aip_back.sv
// Back end of the ASCII integer parser: decimal and hex parsers that run side
// by side, result selection at the zero byte, and the output register.
// Depends on aip_pkg.
`default_nettype none

module aip_back #(
  parameter int MAX_LEN    = aip_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [aip_pkg::MODE_W-1:0]     radix_mode,
  input  wire logic                           q_valid,
  input  wire aip_pkg::char_class_t           q_class,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic signed [aip_pkg::VALUE_W-1:0]  out_parsed_value,
  output logic [aip_pkg::OFFSET_W-1:0]        out_stop_offset,
  input  wire logic                           out_stall
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int VB    = VALUE_BITS;
  localparam int OV_W  = aip_pkg::VALUE_W;
  localparam int OO_W  = aip_pkg::OFFSET_W;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_MINUS = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } hex_phase_t;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       dec_sign_r, dec_sign_nxt;
  logic             dec_seen_r, dec_seen_nxt;
  logic             dec_halted_r, dec_halted_nxt;
  logic [VB-1:0]    dec_acc_r, dec_acc_nxt;
  logic [POS_W-1:0] dec_stop_r, dec_stop_nxt;
  logic [1:0]       hex_sign_r, hex_sign_nxt;
  hex_phase_t       hex_phase_r, hex_phase_nxt;
  logic             hex_halted_r, hex_halted_nxt;
  logic [VB-1:0]    hex_acc_r, hex_acc_nxt;
  logic [POS_W-1:0] hex_stop_r, hex_stop_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OV_W-1:0]        out_value_r, out_value_nxt;
  logic [OO_W-1:0]        out_offset_r, out_offset_nxt;

  logic             out_free;
  logic             take_char;
  logic             take_term;
  logic             dec_fresh, hex_fresh;
  logic [VB-1:0]    dec_val, hex_val, sel_val;
  logic [POS_W-1:0] dec_off, hex_off, sel_off;
  logic [OV_W+VB-1:0]   val_ext;
  logic [OO_W+POS_W-1:0] off_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (!q_class.term || out_free);
  assign take_char = q_pop && !q_class.term;
  assign take_term = q_pop && q_class.term;

  assign dec_fresh = !dec_seen_r && (dec_sign_r == SIGN_NONE);
  assign hex_fresh = (hex_phase_r == PH_NONE) && (hex_sign_r == SIGN_NONE);

  // Answers of the two parsers as they stand at the zero byte.
  always_comb begin
    dec_val = (dec_sign_r == SIGN_MINUS) ? ('0 - dec_acc_r) : dec_acc_r;
    dec_off = dec_halted_r ? dec_stop_r : pos_r;
    if ((dec_sign_r != SIGN_NONE) && !dec_seen_r) begin
      dec_off = '0;
    end
    hex_val = (hex_sign_r == SIGN_MINUS) ? ('0 - hex_acc_r) : hex_acc_r;
    hex_off = hex_halted_r ? hex_stop_r : pos_r;
    if ((hex_phase_r == PH_PREFIX) ||
        ((hex_sign_r != SIGN_NONE) && (hex_phase_r == PH_NONE))) begin
      hex_off = '0;
    end
    unique case (radix_mode)
      aip_pkg::MODE_DEC: begin
        sel_val = dec_val;
        sel_off = dec_off;
      end
      aip_pkg::MODE_HEX: begin
        sel_val = hex_val;
        sel_off = hex_off;
      end
      aip_pkg::MODE_AUTO: begin
        // A negated magnitude is zero only when the magnitude is.
        if (dec_acc_r != '0) begin
          sel_val = dec_val;
          sel_off = dec_off;
        end else begin
          sel_val = hex_val;
          sel_off = hex_off;
        end
      end
      default: begin
        sel_val = '0;
        sel_off = '0;
      end
    endcase
  end

  assign val_ext = {{OV_W{sel_val[VB-1]}}, sel_val};
  assign off_ext = {{OO_W{1'b0}}, sel_off};

  always_comb begin
    pos_nxt        = pos_r;
    dec_sign_nxt   = dec_sign_r;
    dec_seen_nxt   = dec_seen_r;
    dec_halted_nxt = dec_halted_r;
    dec_acc_nxt    = dec_acc_r;
    dec_stop_nxt   = dec_stop_r;
    hex_sign_nxt   = hex_sign_r;
    hex_phase_nxt  = hex_phase_r;
    hex_halted_nxt = hex_halted_r;
    hex_acc_nxt    = hex_acc_r;
    hex_stop_nxt   = hex_stop_r;

    if (take_char) begin
      if (pos_r < POS_W'(MAX_LEN)) begin
        pos_nxt = pos_r + 1'b1;
      end

      if (!dec_halted_r && !(dec_fresh && q_class.blank)) begin
        if (q_class.dec_digit) begin
          dec_seen_nxt = 1'b1;
          dec_acc_nxt  = {dec_acc_r[VB-4:0], 3'b000} + {dec_acc_r[VB-2:0], 1'b0}
                         + VB'(q_class.nib);
        end else if (dec_fresh && q_class.plus) begin
          dec_sign_nxt = SIGN_PLUS;
        end else if (dec_fresh && q_class.minus) begin
          dec_sign_nxt = SIGN_MINUS;
        end else begin
          dec_halted_nxt = 1'b1;
          dec_stop_nxt   = pos_r;
        end
      end

      if (!hex_halted_r && !(hex_fresh && q_class.blank)) begin
        if (q_class.hex_digit) begin
          if ((hex_phase_r == PH_NONE) && q_class.zero) begin
            hex_phase_nxt = PH_ZERO;
          end else begin
            hex_phase_nxt = PH_DIGITS;
            hex_acc_nxt   = {hex_acc_r[VB-5:0], q_class.nib};
          end
        end else if (hex_fresh && q_class.plus) begin
          hex_sign_nxt = SIGN_PLUS;
        end else if (hex_fresh && q_class.minus) begin
          hex_sign_nxt = SIGN_MINUS;
        end else if ((hex_phase_r == PH_ZERO) && q_class.ex) begin
          hex_phase_nxt = PH_PREFIX;
        end else begin
          hex_halted_nxt = 1'b1;
          hex_stop_nxt   = pos_r;
        end
      end
    end else if (take_term) begin
      pos_nxt        = '0;
      dec_sign_nxt   = SIGN_NONE;
      dec_seen_nxt   = 1'b0;
      dec_halted_nxt = 1'b0;
      dec_acc_nxt    = '0;
      dec_stop_nxt   = '0;
      hex_sign_nxt   = SIGN_NONE;
      hex_phase_nxt  = PH_NONE;
      hex_halted_nxt = 1'b0;
      hex_acc_nxt    = '0;
      hex_stop_nxt   = '0;
    end
  end

  // Output register: loaded by a zero byte, held while the receiver stalls.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_offset_nxt = out_offset_r;
    if (take_term) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = val_ext[OV_W-1:0];
      out_offset_nxt = off_ext[OO_W-1:0];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      dec_sign_r   <= SIGN_NONE;
      dec_seen_r   <= 1'b0;
      dec_halted_r <= 1'b0;
      dec_acc_r    <= '0;
      dec_stop_r   <= '0;
      hex_sign_r   <= SIGN_NONE;
      hex_phase_r  <= PH_NONE;
      hex_halted_r <= 1'b0;
      hex_acc_r    <= '0;
      hex_stop_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      dec_sign_r   <= dec_sign_nxt;
      dec_seen_r   <= dec_seen_nxt;
      dec_halted_r <= dec_halted_nxt;
      dec_acc_r    <= dec_acc_nxt;
      dec_stop_r   <= dec_stop_nxt;
      hex_sign_r   <= hex_sign_nxt;
      hex_phase_r  <= hex_phase_nxt;
      hex_halted_r <= hex_halted_nxt;
      hex_acc_r    <= hex_acc_nxt;
      hex_stop_r   <= hex_stop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = out_value_r;
  assign out_stop_offset  = out_offset_r;

endmodule

`default_nettype wire
